/* sv/esz_pkg.sv */
// ----------------------------------------------------------------------------
// esz_pkg: shared types and constants of the effect size estimator
// Field widths, stage payload structs, estimator and status codes, and the
// small-sample correction tables.
// ----------------------------------------------------------------------------
package esz_pkg;

    localparam int CountBits   = 16;
    localparam int DataW       = 32;
    localparam int NW          = CountBits + 1;
    localparam int HedgesLimit = 50;
    localparam int HedgesIdxW  = $clog2(HedgesLimit);
    localparam int HedgesTabN  = 2 ** HedgesIdxW;
    localparam int LxW         = 21;
    localparam int RxHW        = 27;
    localparam int RxW         = (NW > RxHW) ? NW : RxHW;
    localparam int MagW        = DataW + 1;
    localparam int SqW         = 2 * DataW;
    localparam int MagSqW      = 2 * MagW;
    localparam int SumW        = SqW + CountBits + 1;
    localparam int LhsW        = SumW + LxW;
    localparam int RhsW        = MagSqW + RxW + DataW;
    localparam int QW          = DataW + 1;
    localparam int YW          = LhsW + QW;
    localparam int TW          = YW + 2 + QW;

    // split of the wide front products into two half products
    localparam int SumLoW      = (SumW + 1) / 2;
    localparam int SumHiW      = SumW - SumLoW;
    localparam int PlLoW       = SumLoW + LxW;
    localparam int PlHiW       = SumHiW + LxW;
    localparam int MagLoW      = MagSqW / 2;
    localparam int MagHiW      = MagSqW - MagLoW;
    localparam int PrLoW       = MagLoW + RxW;
    localparam int PrHiW       = MagHiW + RxW;

    localparam logic [1:0] FuncCohen  = 2'd0;
    localparam logic [1:0] FuncHedges = 2'd1;
    localparam logic [1:0] FuncGlass  = 2'd2;

    localparam logic [1:0] StOk   = 2'd0;
    localparam logic [1:0] StZero = 2'd1;
    localparam logic [1:0] StSat  = 2'd2;

    typedef struct packed {
        logic glass;   // signed result, Glass's delta
        logic neg;     // negative mean difference (Glass only)
        logic zero;    // zero df or zero divisor
        logic force0;  // Hedges correction of zero
    } t_ctl;

    typedef struct packed {
        logic [LhsW-1:0] lhs;
        logic [RhsW-1:0] rhs;
        t_ctl            ctl;
    } t_front;

    typedef struct packed {
        logic [QW-1:0] q;
        t_ctl          ctl;
    } t_root;

    typedef logic [LxW-1:0]  t_lx_tab [HedgesTabN];
    typedef logic [RxHW-1:0] t_rx_tab [HedgesTabN];

    // (4n-9)^2 * n
    function automatic t_lx_tab build_lx();
        t_lx_tab t;
        longint  v;
        for (int i = 0; i < HedgesTabN; i++) begin
            if (i >= 4 && i < HedgesLimit) v = longint'((4*i-9)*(4*i-9)) * i;
            else v = 0;
            t[i] = LxW'(v);
        end
        return t;
    endfunction

    // 16 * (n-2)^2 * (n-3)^2
    function automatic t_rx_tab build_rx();
        t_rx_tab t;
        longint  v;
        for (int i = 0; i < HedgesTabN; i++) begin
            if (i >= 4 && i < HedgesLimit) v = longint'((i-2)*(i-2)) * 16 * (i-3) * (i-3);
            else v = 0;
            t[i] = RxHW'(v);
        end
        return t;
    endfunction

    localparam t_lx_tab HedgesLx = build_lx();
    localparam t_rx_tab HedgesRx = build_rx();

endpackage

/* sv/esz_if.sv */
// ----------------------------------------------------------------------------
// esz_if: stream channels of the effect size estimator
// Input channel with two group summaries, output channel with one effect.
// ----------------------------------------------------------------------------
interface esz_in_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     func;
    logic signed [esz_pkg::DataW-1:0] mean_a;
    logic [esz_pkg::DataW-1:0]      sd_a;
    logic [esz_pkg::CountBits-1:0]  count_a;
    logic signed [esz_pkg::DataW-1:0] mean_b;
    logic [esz_pkg::DataW-1:0]      sd_b;
    logic [esz_pkg::CountBits-1:0]  count_b;

    modport source (output valid, func, mean_a, sd_a, count_a, mean_b, sd_b, count_b,
                    input ready);
    modport sink   (input valid, func, mean_a, sd_a, count_a, mean_b, sd_b, count_b,
                    output ready);
endinterface

interface esz_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [esz_pkg::DataW-1:0] effect;
    logic [1:0]                       status;

    modport source (output valid, effect, status, input ready);
    modport sink   (input valid, effect, status, output ready);
endinterface

/* sv/esz_prep.sv */
// ----------------------------------------------------------------------------
// esz_prep: front stages
// Five register stages that build the two sides of the root comparison:
// lhs = pooled sum * lx, rhs = diff^2 * rx * 2^32. The wide final products
// are formed as two half products, then summed in the last stage.
// ----------------------------------------------------------------------------
module esz_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    esz_in_if.sink            i_item,
    output logic              o_valid,
    output esz_pkg::t_front   o_front,
    input  logic              i_ready
);

    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic en1, en2, en3, en4, en5;

    // stage 1 payload
    logic signed [esz_pkg::MagW-1:0] r1_diff, n1_diff;
    logic [esz_pkg::SqW-1:0]         r1_sa2, r1_sb2, n1_sa2, n1_sb2;
    logic [esz_pkg::CountBits-1:0]   r1_wa, r1_wb, n1_wa, n1_wb;
    logic [esz_pkg::LxW-1:0]         r1_lx, n1_lx;
    logic [esz_pkg::RxW-1:0]         r1_rx, n1_rx;
    esz_pkg::t_ctl                   r1_ctl, n1_ctl;
    // stage 2
    logic [esz_pkg::MagW-1:0]        r2_mag;
    logic [esz_pkg::SumW-1:0]        r2_pa, r2_pb;
    logic [esz_pkg::LxW-1:0]         r2_lx;
    logic [esz_pkg::RxW-1:0]         r2_rx;
    esz_pkg::t_ctl                   r2_ctl;
    // stage 3
    logic [esz_pkg::SumW-1:0]        r3_s;
    logic [esz_pkg::MagSqW-1:0]      r3_mag2;
    logic [esz_pkg::LxW-1:0]         r3_lx;
    logic [esz_pkg::RxW-1:0]         r3_rx;
    esz_pkg::t_ctl                   r3_ctl;
    // stage 4: half products
    logic [esz_pkg::PlLoW-1:0]       r4_pl_lo;
    logic [esz_pkg::PlHiW-1:0]       r4_pl_hi;
    logic [esz_pkg::PrLoW-1:0]       r4_pr_lo;
    logic [esz_pkg::PrHiW-1:0]       r4_pr_hi;
    esz_pkg::t_ctl                   r4_ctl;
    // stage 5
    esz_pkg::t_front                 r5_front;

    logic [esz_pkg::NW-1:0]          n_sum;
    logic [esz_pkg::HedgesIdxW-1:0]  hidx;
    logic                            hedges, glass;

    assign en5 = !r5_v || i_ready;
    assign en4 = !r4_v || en5;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign i_item.ready = en1;

    always_comb begin
        n_sum  = esz_pkg::NW'(i_item.count_a) + esz_pkg::NW'(i_item.count_b);
        hidx   = n_sum[esz_pkg::HedgesIdxW-1:0];
        glass  = (i_item.func == esz_pkg::FuncGlass);
        hedges = (i_item.func == esz_pkg::FuncHedges)
                 && (n_sum < esz_pkg::NW'(esz_pkg::HedgesLimit));
        n1_diff = esz_pkg::MagW'(i_item.mean_a) - esz_pkg::MagW'(i_item.mean_b);
        n1_sa2  = esz_pkg::SqW'(i_item.sd_a) * esz_pkg::SqW'(i_item.sd_a);
        n1_sb2  = esz_pkg::SqW'(i_item.sd_b) * esz_pkg::SqW'(i_item.sd_b);
        // Glass: pooled sum becomes sd_b^2 alone
        if (glass) begin
            n1_wa = '0;
            n1_wb = esz_pkg::CountBits'(1);
        end else begin
            n1_wa = (i_item.count_a != '0) ? i_item.count_a - 1'b1 : '0;
            n1_wb = (i_item.count_b != '0) ? i_item.count_b - 1'b1 : '0;
        end
        if (hedges) begin
            n1_lx = esz_pkg::HedgesLx[hidx];
            n1_rx = esz_pkg::RxW'(esz_pkg::HedgesRx[hidx]);
        end else if (glass) begin
            n1_lx = esz_pkg::LxW'(1);
            n1_rx = esz_pkg::RxW'(1);
        end else begin
            n1_lx = esz_pkg::LxW'(1);
            n1_rx = esz_pkg::RxW'(n_sum - esz_pkg::NW'(2));
        end
        n1_ctl.glass  = glass;
        n1_ctl.neg    = glass && n1_diff[esz_pkg::MagW-1];
        n1_ctl.zero   = !glass && (n_sum <= esz_pkg::NW'(2));
        n1_ctl.force0 = hedges && (n_sum == esz_pkg::NW'(3));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_item.valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_diff <= n1_diff;
            r1_sa2  <= n1_sa2;
            r1_sb2  <= n1_sb2;
            r1_wa   <= n1_wa;
            r1_wb   <= n1_wb;
            r1_lx   <= n1_lx;
            r1_rx   <= n1_rx;
            r1_ctl  <= n1_ctl;
        end
        if (en2) begin
            r2_mag <= r1_diff[esz_pkg::MagW-1] ? esz_pkg::MagW'(-r1_diff)
                                               : esz_pkg::MagW'(r1_diff);
            r2_pa  <= esz_pkg::SumW'(r1_sa2) * esz_pkg::SumW'(r1_wa);
            r2_pb  <= esz_pkg::SumW'(r1_sb2) * esz_pkg::SumW'(r1_wb);
            r2_lx  <= r1_lx;
            r2_rx  <= r1_rx;
            r2_ctl <= r1_ctl;
        end
        if (en3) begin
            r3_s    <= r2_pa + r2_pb;
            r3_mag2 <= esz_pkg::MagSqW'(r2_mag) * esz_pkg::MagSqW'(r2_mag);
            r3_lx   <= r2_lx;
            r3_rx   <= r2_rx;
            r3_ctl  <= r2_ctl;
        end
        if (en4) begin
            r4_pl_lo <= esz_pkg::PlLoW'(r3_s[esz_pkg::SumLoW-1:0])
                        * esz_pkg::PlLoW'(r3_lx);
            r4_pl_hi <= esz_pkg::PlHiW'(r3_s[esz_pkg::SumW-1:esz_pkg::SumLoW])
                        * esz_pkg::PlHiW'(r3_lx);
            r4_pr_lo <= esz_pkg::PrLoW'(r3_mag2[esz_pkg::MagLoW-1:0])
                        * esz_pkg::PrLoW'(r3_rx);
            r4_pr_hi <= esz_pkg::PrHiW'(r3_mag2[esz_pkg::MagSqW-1:esz_pkg::MagLoW])
                        * esz_pkg::PrHiW'(r3_rx);
            r4_ctl   <= '{glass:  r3_ctl.glass,
                          neg:    r3_ctl.neg,
                          zero:   r3_ctl.zero || (r3_s == '0),
                          force0: r3_ctl.force0};
        end
        if (en5) begin
            r5_front <= '{lhs: (esz_pkg::LhsW'(r4_pl_hi) << esz_pkg::SumLoW)
                               + esz_pkg::LhsW'(r4_pl_lo),
                          rhs: ((esz_pkg::RhsW'(r4_pr_hi) << esz_pkg::MagLoW)
                               + esz_pkg::RhsW'(r4_pr_lo)) << esz_pkg::DataW,
                          ctl: r4_ctl};
        end
    end

    assign o_valid = r5_v;
    assign o_front = r5_front;

endmodule

/* sv/esz_root.sv */
// ----------------------------------------------------------------------------
// esz_root: restoring root search
// One stage per quotient bit, MSB first: finds the largest q with
// q^2 * lhs <= rhs. Keeps the remainder rhs - q^2*lhs and y = q*lhs.
// ----------------------------------------------------------------------------
module esz_root (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  esz_pkg::t_front i_front,
    output logic            o_ready,
    output logic            o_valid,
    output esz_pkg::t_root  o_res,
    input  logic            i_ready
);

    logic                     r_v   [esz_pkg::QW];
    logic [esz_pkg::RhsW-1:0] r_rem [esz_pkg::QW];
    logic [esz_pkg::YW-1:0]   r_y   [esz_pkg::QW];
    logic [esz_pkg::QW-1:0]   r_q   [esz_pkg::QW];
    logic [esz_pkg::LhsW-1:0] r_lhs [esz_pkg::QW];
    esz_pkg::t_ctl            r_ctl [esz_pkg::QW];
    logic [esz_pkg::QW:0]     en;

    assign en[esz_pkg::QW] = i_ready;
    assign o_ready = en[0];

    for (genvar k = 0; k < esz_pkg::QW; k++) begin : g_stage
        localparam int Bit = esz_pkg::QW - 1 - k;
        logic                     v_in;
        logic [esz_pkg::RhsW-1:0] rem_in;
        logic [esz_pkg::YW-1:0]   y_in;
        logic [esz_pkg::QW-1:0]   q_in;
        logic [esz_pkg::LhsW-1:0] lhs_in;
        esz_pkg::t_ctl            ctl_in;
        logic [esz_pkg::YW-1:0]   add;
        logic [esz_pkg::TW-1:0]   trial;
        logic                     fit;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign rem_in = i_front.rhs;
            assign y_in   = '0;
            assign q_in   = '0;
            assign lhs_in = i_front.lhs;
            assign ctl_in = i_front.ctl;
        end else begin : g_next
            assign v_in   = r_v[k-1];
            assign rem_in = r_rem[k-1];
            assign y_in   = r_y[k-1];
            assign q_in   = r_q[k-1];
            assign lhs_in = r_lhs[k-1];
            assign ctl_in = r_ctl[k-1];
        end

        assign en[k] = !r_v[k] || en[k+1];

        // (q + 2^b)^2 lhs - q^2 lhs = (2y + lhs*2^b) * 2^b
        assign add   = esz_pkg::YW'(lhs_in) << Bit;
        assign trial = (esz_pkg::TW'({y_in, 1'b0}) + esz_pkg::TW'(add)) << Bit;
        assign fit   = trial <= esz_pkg::TW'(rem_in);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (en[k]) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_lhs[k] <= lhs_in;
                r_ctl[k] <= ctl_in;
                if (fit) begin
                    r_rem[k] <= rem_in - trial[esz_pkg::RhsW-1:0];
                    r_y[k]   <= y_in + add;
                    r_q[k]   <= q_in | (esz_pkg::QW'(1) << Bit);
                end else begin
                    r_rem[k] <= rem_in;
                    r_y[k]   <= y_in;
                    r_q[k]   <= q_in;
                end
            end
        end
    end

    assign o_valid   = r_v[esz_pkg::QW-1];
    assign o_res.q   = r_q[esz_pkg::QW-1];
    assign o_res.ctl = r_ctl[esz_pkg::QW-1];

endmodule

/* sv/esz_post.sv */
// ----------------------------------------------------------------------------
// esz_post: result formatting and output register
// Applies sign, saturation, the zero-divisor case and the forced-zero Hedges
// case, then holds the beat until the sink takes it.
// ----------------------------------------------------------------------------
module esz_post (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  esz_pkg::t_root i_res,
    output logic           o_ready,
    esz_out_if.source      o_result
);

    localparam logic [esz_pkg::QW-1:0] NegLim = esz_pkg::QW'(1) << (esz_pkg::DataW - 1);
    localparam logic [esz_pkg::QW-1:0] PosLim = NegLim - 1'b1;
    localparam logic [esz_pkg::DataW-1:0] EffMax = {1'b0, {(esz_pkg::DataW-1){1'b1}}};
    localparam logic [esz_pkg::DataW-1:0] EffMin = {1'b1, {(esz_pkg::DataW-1){1'b0}}};

    logic                      r_valid;
    logic [esz_pkg::DataW-1:0] r_effect, n_effect;
    logic [1:0]                r_status, n_status;
    logic                      en;

    assign en      = !r_valid || o_result.ready;
    assign o_ready = en;

    always_comb begin
        n_effect = '0;
        n_status = esz_pkg::StOk;
        if (i_res.ctl.zero) begin
            n_status = esz_pkg::StZero;
        end else if (i_res.ctl.force0) begin
            n_status = esz_pkg::StOk;
        end else if (i_res.ctl.neg) begin
            if (i_res.q > NegLim) begin
                n_effect = EffMin;
                n_status = esz_pkg::StSat;
            end else begin
                n_effect = '0 - i_res.q[esz_pkg::DataW-1:0];
            end
        end else if (i_res.q > PosLim) begin
            n_effect = EffMax;
            n_status = esz_pkg::StSat;
        end else begin
            n_effect = i_res.q[esz_pkg::DataW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_effect <= n_effect;
            r_status <= n_status;
        end
    end

    assign o_result.valid  = r_valid;
    assign o_result.effect = r_effect;
    assign o_result.status = r_status;

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.status == esz_pkg::StSat
        |-> o_result.effect == EffMax || o_result.effect == EffMin)
        else $error("saturated beat without an extreme effect");

    a_zero_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.status == esz_pkg::StZero |-> o_result.effect == '0)
        else $error("zero-divisor beat with nonzero effect");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.status == esz_pkg::StOk
            || o_result.status == esz_pkg::StZero || o_result.status == esz_pkg::StSat)
        else $error("undefined status code");

endmodule

/* sv/effect_size_estimator_core.sv */
// ----------------------------------------------------------------------------
// effect_size_estimator_core: Cohen's d, Hedges' g and Glass's delta
// Pipeline: 5 front stages, 33 root-search stages, 1 output register.
// Throughput one beat per cycle; each stage stalls only when it is full and
// the next one cannot take its beat.
// Synchronous active-low reset clears all valid bits; payloads are not reset.
// ----------------------------------------------------------------------------
module effect_size_estimator_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    esz_in_if.sink    i_item,
    esz_out_if.source o_result
);

    logic            front_valid, front_ready;
    esz_pkg::t_front front;
    logic            root_valid, root_ready;
    esz_pkg::t_root  root;

    esz_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (front_valid),
        .o_front (front),
        .i_ready (front_ready)
    );

    esz_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .i_front (front),
        .o_ready (front_ready),
        .o_valid (root_valid),
        .o_res   (root),
        .i_ready (root_ready)
    );

    esz_post u_post (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (root_valid),
        .i_res    (root),
        .o_ready  (root_ready),
        .o_result (o_result)
    );

endmodule
